@@ design/wavp_pkg.sv @@
// shared types and constants for the wav header chunk parser
package wavp_pkg;

    localparam int QueueDepth = 2;

    // byte position only matters up to offset 35, beyond that it saturates
    localparam int PosW = 6;
    localparam logic [PosW-1:0] PosSat = 6'd36;

    localparam logic [3:0] ChunkLimitReset = 4'd10;

    localparam logic [31:0] TagRiff = 32'h5249_4646;
    localparam logic [31:0] TagWave = 32'h5741_5645;
    localparam logic [31:0] TagData = 32'h6461_7461;

    localparam logic [2:0] StHeader      = 3'd0;
    localparam logic [2:0] StPayload     = 3'd1;
    localparam logic [2:0] StDone        = 3'd2;
    localparam logic [2:0] StBadRiff     = 3'd3;
    localparam logic [2:0] StBadWave     = 3'd4;
    localparam logic [2:0] StBadChannels = 3'd5;
    localparam logic [2:0] StNoData      = 3'd6;
    localparam logic [2:0] StTruncated   = 3'd7;

    typedef enum logic [3:0] {
        CAP_NONE,
        CAP_FMT_LO,
        CAP_FMT_HI,
        CAP_CH_LO,
        CAP_CH_HI,
        CAP_RATE_0,
        CAP_RATE_1,
        CAP_RATE_2,
        CAP_RATE_3,
        CAP_BITS_LO,
        CAP_BITS_HI
    } cap_sel_t;

    typedef struct packed {
        cap_sel_t cap;
        logic     riff_chk;
        logic     wave_chk;
        logic     chan_chk;
    } byte_class_t;

    typedef struct packed {
        logic [7:0]  data;
        logic        eof;
        byte_class_t cls;
    } entry_t;

    typedef enum logic [3:0] {
        PH_HEADER   = 4'b0001,
        PH_WALK     = 4'b0010,
        PH_PAYLOAD  = 4'b0100,
        PH_FINISHED = 4'b1000
    } phase_t;

endpackage

@@ design/wavp_front.sv @@
// input side: accepts bytes, tracks file offset and classifies each byte
module wavp_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [7:0]       byte_value,
    input  logic             end_of_file,
    input  logic             queue_full,
    output logic             push,
    output wavp_pkg::entry_t push_entry
);
    import wavp_pkg::*;

    logic [PosW-1:0] pos_reg;
    logic [PosW-1:0] pos_next;
    byte_class_t     cls;

    assign in_stall = queue_full;
    assign push     = in_valid && !queue_full;

    always_comb
    begin
        cls          = '0;
        cls.cap      = CAP_NONE;
        cls.riff_chk = (pos_reg == 6'd3);
        cls.wave_chk = (pos_reg == 6'd11);
        cls.chan_chk = (pos_reg == 6'd23);
        case (pos_reg)
            6'd20:   cls.cap = CAP_FMT_LO;
            6'd21:   cls.cap = CAP_FMT_HI;
            6'd22:   cls.cap = CAP_CH_LO;
            6'd23:   cls.cap = CAP_CH_HI;
            6'd24:   cls.cap = CAP_RATE_0;
            6'd25:   cls.cap = CAP_RATE_1;
            6'd26:   cls.cap = CAP_RATE_2;
            6'd27:   cls.cap = CAP_RATE_3;
            6'd34:   cls.cap = CAP_BITS_LO;
            6'd35:   cls.cap = CAP_BITS_HI;
            default: cls.cap = CAP_NONE;
        endcase
    end

    assign push_entry.data = byte_value;
    assign push_entry.eof  = end_of_file;
    assign push_entry.cls  = cls;

    always_comb
    begin
        pos_next = pos_reg;
        if (push)
        begin
            if (end_of_file)
                pos_next = '0;
            else if (pos_reg != PosSat)
                pos_next = pos_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pos_reg <= '0;
        else
            pos_reg <= pos_next;
    end

endmodule

@@ design/wavp_queue.sv @@
// short fifo of classified bytes between the front and the back
module wavp_queue #(
    parameter int DEPTH = wavp_pkg::QueueDepth
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  wavp_pkg::entry_t push_entry,
    input  logic             pop,
    output logic             full,
    output logic             not_empty,
    output wavp_pkg::entry_t head
);
    import wavp_pkg::*;

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

    entry_t          slots [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [PtrW-1:0] rd_ptr_next;
    logic [CntW-1:0] count_reg;
    logic [CntW-1:0] count_next;

    assign full      = (count_reg == FullCnt);
    assign not_empty = (count_reg != '0);
    assign head      = slots[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slots[wr_ptr_reg] <= push_entry;
    end

endmodule

@@ design/wavp_back.sv @@
// parse engine: header checks, field capture, chunk walk, payload pass and result register
module wavp_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             not_empty,
    input  wavp_pkg::entry_t head,
    output logic             pop,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [3:0]       cfg_data,
    output logic             out_valid,
    input  logic             out_stall,
    output logic             payload_valid,
    output logic [7:0]       payload_byte,
    output logic             payload_last,
    output logic [15:0]      audio_format,
    output logic [15:0]      num_channels,
    output logic [31:0]      sample_freq,
    output logic [15:0]      bits_per_sample,
    output logic [31:0]      payload_size,
    output logic [2:0]       status
);
    import wavp_pkg::*;

    logic [3:0]  limit_reg;

    phase_t      phase_reg, phase_next, phase_cur;
    logic [63:0] shift_reg, shift_next;
    logic [2:0]  hcount_reg, hcount_next;
    logic [31:0] skip_reg, skip_next;
    logic [3:0]  chunks_reg, chunks_next;
    logic [15:0] fmt_reg, fmt_next;
    logic [15:0] ch_reg, ch_next;
    logic [31:0] rate_reg, rate_next;
    logic [15:0] bits_reg, bits_next;
    logic [31:0] remain_reg, remain_next;
    logic [31:0] psize_reg, psize_next;
    logic [2:0]  status_reg, status_next;

    logic        res_valid, res_last;
    logic [31:0] chunk_size;
    logic [3:0]  chunks_dec;
    logic [31:0] remain_dec;

    logic        ovalid_reg;
    logic        pv_reg, plast_reg;
    logic [7:0]  pbyte_reg;
    logic [15:0] ofmt_reg, och_reg, obits_reg;
    logic [31:0] orate_reg, opsize_reg;
    logic [2:0]  ostatus_reg;

    assign pop       = not_empty && (!ovalid_reg || !out_stall);
    assign cfg_ready = 1'b1;

    assign chunks_dec = chunks_reg - 1'b1;
    assign remain_dec = remain_reg - 1'b1;

    // size field is little endian: oldest of the last four bytes is the low byte
    assign chunk_size = {head.data, shift_reg[7:0], shift_reg[15:8], shift_reg[23:16]};

    always_comb
    begin
        phase_next  = phase_reg;
        shift_next  = shift_reg;
        hcount_next = hcount_reg;
        skip_next   = skip_reg;
        chunks_next = chunks_reg;
        fmt_next    = fmt_reg;
        ch_next     = ch_reg;
        rate_next   = rate_reg;
        bits_next   = bits_reg;
        remain_next = remain_reg;
        psize_next  = psize_reg;
        status_next = status_reg;
        res_valid   = 1'b0;
        res_last    = 1'b0;
        phase_cur   = phase_reg;

        if (status_reg < StBadRiff)
        begin
            case (head.cls.cap)
                CAP_FMT_LO:  fmt_next[7:0]    = head.data;
                CAP_FMT_HI:  fmt_next[15:8]   = head.data;
                CAP_CH_LO:   ch_next[7:0]     = head.data;
                CAP_CH_HI:   ch_next[15:8]    = head.data;
                CAP_RATE_0:  rate_next[7:0]   = head.data;
                CAP_RATE_1:  rate_next[15:8]  = head.data;
                CAP_RATE_2:  rate_next[23:16] = head.data;
                CAP_RATE_3:  rate_next[31:24] = head.data;
                CAP_BITS_LO: bits_next[7:0]   = head.data;
                CAP_BITS_HI: bits_next[15:8]  = head.data;
                default:     ;
            endcase
        end

        // channel check overrides whatever the walk or payload would do with this byte
        if (head.cls.chan_chk && status_reg < StBadRiff
            && ch_next != 16'd1 && ch_next != 16'd2)
        begin
            phase_cur   = PH_FINISHED;
            phase_next  = PH_FINISHED;
            status_next = StBadChannels;
        end

        case (phase_cur)
            PH_HEADER:
            begin
                shift_next = {shift_reg[55:0], head.data};
                if (head.cls.riff_chk && shift_next[31:0] != TagRiff)
                begin
                    phase_next  = PH_FINISHED;
                    status_next = StBadRiff;
                end
                else if (head.cls.wave_chk)
                begin
                    if (shift_next[31:0] != TagWave)
                    begin
                        phase_next  = PH_FINISHED;
                        status_next = StBadWave;
                    end
                    else
                    begin
                        phase_next  = PH_WALK;
                        shift_next  = '0;
                        hcount_next = '0;
                        skip_next   = '0;
                        chunks_next = limit_reg;
                    end
                end
            end
            PH_WALK:
            begin
                if (skip_reg != '0)
                    skip_next = skip_reg - 1'b1;
                else
                begin
                    shift_next = {shift_reg[55:0], head.data};
                    if (hcount_reg != 3'd7)
                        hcount_next = hcount_reg + 1'b1;
                    else
                    begin
                        // eighth header byte: id and size complete
                        hcount_next = '0;
                        if (chunks_reg == '0)
                        begin
                            phase_next  = PH_FINISHED;
                            status_next = StNoData;
                        end
                        else if (shift_next[63:32] == TagData)
                        begin
                            psize_next = chunk_size;
                            if (chunk_size == '0)
                            begin
                                phase_next  = PH_FINISHED;
                                status_next = StDone;
                            end
                            else
                            begin
                                remain_next = chunk_size;
                                phase_next  = PH_PAYLOAD;
                                status_next = StPayload;
                            end
                        end
                        else
                        begin
                            chunks_next = chunks_dec;
                            if (chunks_dec == '0)
                            begin
                                phase_next  = PH_FINISHED;
                                status_next = StNoData;
                            end
                            else
                                skip_next = chunk_size;
                        end
                    end
                end
            end
            PH_PAYLOAD:
            begin
                res_valid   = 1'b1;
                remain_next = remain_dec;
                if (remain_dec == '0)
                begin
                    res_last    = 1'b1;
                    phase_next  = PH_FINISHED;
                    status_next = StDone;
                end
            end
            default: ;
        endcase

        if (head.eof)
        begin
            if (phase_next == PH_HEADER || phase_next == PH_PAYLOAD)
                status_next = StTruncated;
            else if (phase_next == PH_WALK)
                status_next = StNoData;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= ChunkLimitReset;
        else if (cfg_valid && cfg_ready)
            limit_reg <= cfg_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            shift_reg  <= '0;
            hcount_reg <= '0;
            skip_reg   <= '0;
            chunks_reg <= '0;
            fmt_reg    <= '0;
            ch_reg     <= '0;
            rate_reg   <= '0;
            bits_reg   <= '0;
            remain_reg <= '0;
            psize_reg  <= '0;
            status_reg <= StHeader;
        end
        else if (pop)
        begin
            if (head.eof)
            begin
                // end of file rearms for the next file
                phase_reg  <= PH_HEADER;
                shift_reg  <= '0;
                hcount_reg <= '0;
                skip_reg   <= '0;
                chunks_reg <= '0;
                fmt_reg    <= '0;
                ch_reg     <= '0;
                rate_reg   <= '0;
                bits_reg   <= '0;
                remain_reg <= '0;
                psize_reg  <= '0;
                status_reg <= StHeader;
            end
            else
            begin
                phase_reg  <= phase_next;
                shift_reg  <= shift_next;
                hcount_reg <= hcount_next;
                skip_reg   <= skip_next;
                chunks_reg <= chunks_next;
                fmt_reg    <= fmt_next;
                ch_reg     <= ch_next;
                rate_reg   <= rate_next;
                bits_reg   <= bits_next;
                remain_reg <= remain_next;
                psize_reg  <= psize_next;
                status_reg <= status_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ovalid_reg <= 1'b0;
        else if (pop)
            ovalid_reg <= 1'b1;
        else if (!out_stall)
            ovalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            pv_reg      <= res_valid;
            pbyte_reg   <= res_valid ? head.data : 8'd0;
            plast_reg   <= res_last;
            ofmt_reg    <= fmt_next;
            och_reg     <= ch_next;
            orate_reg   <= rate_next;
            obits_reg   <= bits_next;
            opsize_reg  <= psize_next;
            ostatus_reg <= status_next;
        end
    end

    assign out_valid       = ovalid_reg;
    assign payload_valid   = pv_reg;
    assign payload_byte    = pbyte_reg;
    assign payload_last    = plast_reg;
    assign audio_format    = ofmt_reg;
    assign num_channels    = och_reg;
    assign sample_freq     = orate_reg;
    assign bits_per_sample = obits_reg;
    assign payload_size    = opsize_reg;
    assign status          = ostatus_reg;

endmodule

@@ design/wav_header_chunk_parser.sv @@
// top level of the riff/wave header parser
//
// Input channel: one file byte per word (byte_value, end_of_file) on
// in_valid / in_stall. end_of_file marks the final byte and rearms the parser.
// Output channel: one result word per input byte on out_valid / out_stall:
// payload pass-through flags, captured format fields, data size and status.
// Config channel: cfg_valid / cfg_ready writes chunk_limit (reset 10); write it
// only while no bytes are in flight. cfg_ready is always high.
//
// An accepted byte is held in the front queue and then registered in the engine's
// result register before its result word appears on the outputs.
// Throughput: one byte per cycle while out_stall is low; the engine does one compare,
// shift and counter update per byte from the queue head.
// A stalled output holds its word; the queue then fills and in_stall rises
// once it holds QUEUE_DEPTH bytes.
// Reset: queue empty, no result pending, chunk_limit back to 10, parser
// waits for offset 0 of a new file.
module wav_header_chunk_parser #(
    parameter int QUEUE_DEPTH = wavp_pkg::QueueDepth
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  byte_value,
    input  logic        end_of_file,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        payload_valid,
    output logic [7:0]  payload_byte,
    output logic        payload_last,
    output logic [15:0] audio_format,
    output logic [15:0] num_channels,
    output logic [31:0] sample_freq,
    output logic [15:0] bits_per_sample,
    output logic [31:0] payload_size,
    output logic [2:0]  status
);
    import wavp_pkg::*;

    logic   push, pop, queue_full, queue_not_empty;
    entry_t push_entry, head;

    wavp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .byte_value (byte_value),
        .end_of_file(end_of_file),
        .queue_full (queue_full),
        .push       (push),
        .push_entry (push_entry)
    );

    wavp_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_entry(push_entry),
        .pop       (pop),
        .full      (queue_full),
        .not_empty (queue_not_empty),
        .head      (head)
    );

    wavp_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .not_empty      (queue_not_empty),
        .head           (head),
        .pop            (pop),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .payload_valid  (payload_valid),
        .payload_byte   (payload_byte),
        .payload_last   (payload_last),
        .audio_format   (audio_format),
        .num_channels   (num_channels),
        .sample_freq    (sample_freq),
        .bits_per_sample(bits_per_sample),
        .payload_size   (payload_size),
        .status         (status)
    );

endmodule

@@ design/wavp_checker.sv @@
// port-level checks for the wav header chunk parser, bound to the top level
module wavp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic        payload_valid,
    input logic [7:0]  payload_byte,
    input logic        payload_last,
    input logic [31:0] payload_size,
    input logic [2:0]  status
);
    import wavp_pkg::*;

    // a stalled result word keeps its status and size
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(payload_size))
        else $error("stalled result changed");

    a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && payload_last |-> payload_valid && status == StDone)
        else $error("payload_last without done payload byte");

    a_valid_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && payload_valid |->
            status == StPayload || status == StDone || status == StTruncated)
        else $error("payload byte with wrong status");

    a_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !payload_valid |-> payload_byte == 8'd0 && !payload_last)
        else $error("non-payload word carries payload");

    a_size_known: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && payload_valid |-> payload_size != 32'd0)
        else $error("payload byte before data size");

endmodule

bind wav_header_chunk_parser wavp_checker u_wavp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .payload_valid(payload_valid),
    .payload_byte (payload_byte),
    .payload_last (payload_last),
    .payload_size (payload_size),
    .status       (status)
);

@@ tb/wav_header_chunk_parser_tb.sv @@
// self-checking testbench for the wav header chunk parser: directed table plus random files
`timescale 1ns / 1ps

module wav_header_chunk_parser_tb;

    import wavp_pkg::*;

    localparam logic [31:0] TagFmt  = 32'h666d_7420;
    localparam logic [31:0] TagList = 32'h4c49_5354;
    localparam int KindCount = 11;
    localparam int ItemQuota = 700;

    typedef struct packed {
        logic        pv;
        logic [7:0]  pb;
        logic        pl;
        logic [15:0] fmt;
        logic [15:0] chans;
        logic [31:0] rate;
        logic [15:0] bits;
        logic [31:0] psize;
        logic [2:0]  status;
    } wav_result_t;

    typedef struct packed {
        logic [7:0] data;
        logic       eof;
        logic       pinned;
        logic [2:0] status;
    } stim_row_t;

    typedef enum int {
        F_GOOD,
        F_BAD_RIFF,
        F_BAD_WAVE,
        F_BAD_CH,
        F_EMPTY_DATA,
        F_CUT_HEADER,
        F_CUT_WALK,
        F_CUT_PAYLOAD,
        F_DATA_FIRST,
        F_HUGE_SKIP,
        F_NOISE
    } file_kind_t;

    // short files with an error or an early end; status is pinned where obvious
    localparam stim_row_t DIRECTED_ROWS [23] = '{
        '{8'h52, 1'b0, 1'b1, StHeader},
        '{8'h49, 1'b0, 1'b0, StHeader},
        '{8'h46, 1'b0, 1'b0, StHeader},
        '{8'h58, 1'b0, 1'b1, StBadRiff},
        '{8'hff, 1'b1, 1'b1, StBadRiff},
        '{8'h52, 1'b0, 1'b1, StHeader},
        '{8'h49, 1'b0, 1'b0, StHeader},
        '{8'h46, 1'b0, 1'b0, StHeader},
        '{8'h46, 1'b0, 1'b1, StHeader},
        '{8'h00, 1'b1, 1'b1, StTruncated},
        '{8'h52, 1'b0, 1'b0, StHeader},
        '{8'h49, 1'b0, 1'b0, StHeader},
        '{8'h46, 1'b0, 1'b0, StHeader},
        '{8'h46, 1'b0, 1'b0, StHeader},
        '{8'hff, 1'b0, 1'b0, StHeader},
        '{8'hff, 1'b0, 1'b0, StHeader},
        '{8'hff, 1'b0, 1'b0, StHeader},
        '{8'hff, 1'b0, 1'b0, StHeader},
        '{8'h57, 1'b0, 1'b0, StHeader},
        '{8'h41, 1'b0, 1'b0, StHeader},
        '{8'h56, 1'b0, 1'b0, StHeader},
        '{8'h58, 1'b0, 1'b1, StBadWave},
        '{8'h00, 1'b1, 1'b1, StBadWave}
    };

    localparam logic [3:0] LIMIT_PLAN [7] = '{4'd10, 4'd0, 4'd15, 4'd1, 4'd3, 4'd7, 4'd2};

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  byte_value;
    logic        end_of_file;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [3:0]  cfg_data;
    logic        out_valid;
    logic        out_stall;
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic        payload_last;
    logic [15:0] audio_format;
    logic [15:0] num_channels;
    logic [31:0] sample_freq;
    logic [15:0] bits_per_sample;
    logic [31:0] payload_size;
    logic [2:0]  status;

    wav_header_chunk_parser dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .byte_value      (byte_value),
        .end_of_file     (end_of_file),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .payload_valid   (payload_valid),
        .payload_byte    (payload_byte),
        .payload_last    (payload_last),
        .audio_format    (audio_format),
        .num_channels    (num_channels),
        .sample_freq     (sample_freq),
        .bits_per_sample (bits_per_sample),
        .payload_size    (payload_size),
        .status          (status)
    );

    // parser state as the testbench sees it
    logic [3:0]  limit_reg;
    logic [31:0] pos_cnt;
    phase_t      phase;
    logic [63:0] hdr_shift;
    logic [3:0]  hdr_cnt;
    logic [31:0] skip_left;
    logic [3:0]  chunks_left;
    logic [15:0] fmt_cap;
    logic [15:0] chan_cap;
    logic [31:0] rate_cap;
    logic [15:0] bits_cap;
    logic [31:0] pay_left;
    logic [31:0] pay_size;
    logic [2:0]  st;

    wav_result_t pending_results [$];
    logic [7:0]  file_q [$];
    int          fail_count;
    logic        quiet;
    logic        hold_ask;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    task automatic rearm_parser();
        pos_cnt = '0;
        phase = PH_HEADER;
        hdr_shift = '0;
        hdr_cnt = '0;
        skip_left = '0;
        chunks_left = '0;
        fmt_cap = '0;
        chan_cap = '0;
        rate_cap = '0;
        bits_cap = '0;
        pay_left = '0;
        pay_size = '0;
        st = StHeader;
    endtask

    task automatic end_parse(input logic [2:0] code);
        phase = PH_FINISHED;
        st = code;
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic eof, output wav_result_t r);
        logic [31:0] pos;
        logic [31:0] id;
        logic [31:0] raw;
        logic [31:0] size;
        logic        pv;
        logic        pl;
        pos = pos_cnt;
        pv = 1'b0;
        pl = 1'b0;
        if (st < StBadRiff)
        begin
            case (pos)
                32'd20: fmt_cap[7:0] = b;
                32'd21: fmt_cap[15:8] = b;
                32'd22: chan_cap[7:0] = b;
                32'd23: chan_cap[15:8] = b;
                32'd24: rate_cap[7:0] = b;
                32'd25: rate_cap[15:8] = b;
                32'd26: rate_cap[23:16] = b;
                32'd27: rate_cap[31:24] = b;
                32'd34: bits_cap[7:0] = b;
                32'd35: bits_cap[15:8] = b;
                default: ;
            endcase
        end
        if (pos == 32'd23 && st < StBadRiff && chan_cap != 16'd1 && chan_cap != 16'd2)
            end_parse(StBadChannels);
        case (phase)
            PH_HEADER:
            begin
                hdr_shift = {hdr_shift[55:0], b};
                if (pos == 32'd3 && hdr_shift[31:0] != TagRiff)
                begin
                    end_parse(StBadRiff);
                end
                else if (pos == 32'd11)
                begin
                    if (hdr_shift[31:0] != TagWave)
                    begin
                        end_parse(StBadWave);
                    end
                    else
                    begin
                        phase = PH_WALK;
                        hdr_shift = '0;
                        hdr_cnt = '0;
                        skip_left = '0;
                        chunks_left = limit_reg;
                    end
                end
            end
            PH_WALK:
            begin
                if (skip_left != 0)
                begin
                    skip_left--;
                end
                else
                begin
                    hdr_shift = {hdr_shift[55:0], b};
                    hdr_cnt++;
                    if (hdr_cnt == 4'd8)
                    begin
                        hdr_cnt = '0;
                        id = hdr_shift[63:32];
                        raw = hdr_shift[31:0];
                        // size field is little endian
                        size = {raw[7:0], raw[15:8], raw[23:16], raw[31:24]};
                        if (chunks_left == 0)
                        begin
                            end_parse(StNoData);
                        end
                        else if (id == TagData)
                        begin
                            pay_size = size;
                            if (size == 0)
                            begin
                                end_parse(StDone);
                            end
                            else
                            begin
                                pay_left = size;
                                phase = PH_PAYLOAD;
                                st = StPayload;
                            end
                        end
                        else
                        begin
                            chunks_left--;
                            if (chunks_left == 0)
                                end_parse(StNoData);
                            else
                                skip_left = size;
                        end
                    end
                end
            end
            PH_PAYLOAD:
            begin
                pv = 1'b1;
                pay_left--;
                if (pay_left == 0)
                begin
                    pl = 1'b1;
                    end_parse(StDone);
                end
            end
            default: ;
        endcase
        if (eof)
        begin
            if (phase == PH_HEADER || phase == PH_PAYLOAD)
                end_parse(StTruncated);
            else if (phase == PH_WALK)
                end_parse(StNoData);
        end
        r.pv = pv;
        r.pb = pv ? b : 8'd0;
        r.pl = pl;
        r.fmt = fmt_cap;
        r.chans = chan_cap;
        r.rate = rate_cap;
        r.bits = bits_cap;
        r.psize = pay_size;
        r.status = st;
        if (pos_cnt != 32'hffff_ffff)
            pos_cnt++;
        if (eof)
            rearm_parser();
    endtask

    function automatic int pick_gap_len();
        return ($urandom_range(0, 9) != 0) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    endfunction

    function automatic logic [7:0] rand_byte();
        logic [31:0] v;
        v = $urandom;
        return v[7:0];
    endfunction

    task automatic push_tag(input logic [31:0] tag);
        file_q.push_back(tag[31:24]);
        file_q.push_back(tag[23:16]);
        file_q.push_back(tag[15:8]);
        file_q.push_back(tag[7:0]);
    endtask

    task automatic push_le16(input logic [31:0] v);
        file_q.push_back(v[7:0]);
        file_q.push_back(v[15:8]);
    endtask

    task automatic push_le32(input logic [31:0] v);
        push_le16(v);
        push_le16({16'd0, v[31:16]});
    endtask

    function automatic file_kind_t pick_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return F_GOOD;
        if (r < 60) return F_BAD_RIFF;
        if (r < 64) return F_BAD_WAVE;
        if (r < 69) return F_BAD_CH;
        if (r < 74) return F_EMPTY_DATA;
        if (r < 79) return F_CUT_HEADER;
        if (r < 84) return F_CUT_WALK;
        if (r < 89) return F_CUT_PAYLOAD;
        if (r < 93) return F_DATA_FIRST;
        if (r < 96) return F_HUGE_SKIP;
        return F_NOISE;
    endfunction

    task automatic build_file(input file_kind_t kind);
        int          n;
        int          sz;
        int          body_len;
        int          cut;
        int          data_end;
        int          idx;
        logic [31:0] w;
        logic [31:0] psize;
        file_q.delete();
        if (kind == F_NOISE)
        begin
            n = $urandom_range(1, 48);
            repeat (n) file_q.push_back(rand_byte());
            return;
        end
        push_tag(TagRiff);
        push_le32($urandom);
        push_tag(TagWave);
        if (kind != F_DATA_FIRST)
        begin
            push_tag(TagFmt);
            push_le32(32'd16);
            push_le16(($urandom_range(0, 3) == 0) ? $urandom : 32'd1);
            w = $urandom_range(1, 2);
            if (kind == F_BAD_CH)
            begin
                case ($urandom_range(0, 3))
                    0: w = 32'd0;
                    1: w = 32'd3;
                    2: w = 32'h0100;
                    default: w = $urandom;
                endcase
                if (w[15:0] == 16'd1 || w[15:0] == 16'd2)
                    w = 32'h0000_ffff;
            end
            push_le16(w);
            push_le32($urandom_range(0, 1) ? 32'd44100 : $urandom);
            push_le32($urandom);
            push_le16($urandom);
            push_le16($urandom_range(0, 1) ? 32'd16 : $urandom);
            n = $urandom_range(0, 3);
            repeat (n)
            begin
                push_tag($urandom_range(0, 1) ? TagList : $urandom);
                sz = $urandom_range(0, 10);
                push_le32(sz);
                repeat (sz) file_q.push_back(rand_byte());
            end
            if (kind == F_HUGE_SKIP)
            begin
                // body far longer than the file, so the walk runs into end of file
                push_tag(TagList);
                push_le32(32'hffff_ffff);
                n = $urandom_range(1, 20);
                repeat (n) file_q.push_back(rand_byte());
                return;
            end
        end
        push_tag(TagData);
        case (kind)
            F_EMPTY_DATA: psize = 32'd0;
            F_CUT_PAYLOAD: psize = $urandom_range(0, 1) ? 32'hffff_ffff : $urandom_range(2, 30);
            default: psize = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                         : $urandom_range(1, 24);
        endcase
        push_le32(psize);
        data_end = file_q.size();
        if (kind == F_CUT_PAYLOAD)
            body_len = (psize > 32'd300) ? $urandom_range(1, 20) : $urandom_range(1, psize - 1);
        else
            body_len = psize + $urandom_range(0, 4);
        repeat (body_len) file_q.push_back(rand_byte());
        case (kind)
            F_BAD_RIFF:
            begin
                idx = $urandom_range(0, 3);
                file_q[idx] = file_q[idx] ^ (8'd1 << $urandom_range(0, 7));
            end
            F_BAD_WAVE:
            begin
                idx = $urandom_range(8, 11);
                file_q[idx] = file_q[idx] ^ (8'd1 << $urandom_range(0, 7));
            end
            default: ;
        endcase
        case (kind)
            F_CUT_HEADER: cut = $urandom_range(1, 12);
            F_CUT_WALK: cut = $urandom_range(13, data_end);
            default: cut = file_q.size();
        endcase
        while (file_q.size() > cut)
            void'(file_q.pop_back());
    endtask

    task automatic send_byte(input logic [7:0] b, input logic eof, input logic pinned,
                             input logic [2:0] pin_status);
        int          gap;
        wav_result_t r;
        gap = quiet ? 0 : (($urandom_range(0, 3) == 0) ? pick_gap_len() : 0);
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        byte_value <= b;
        end_of_file <= eof;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        parse_byte(b, eof, r);
        if (pinned)
            r.status = pin_status;
        pending_results.push_back(r);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    task automatic write_limit(input logic [3:0] v);
        wait_drained();
        repeat (3) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        limit_reg = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic check_field(input string name, input logic [31:0] expv,
                               input logic [31:0] actv);
        if (expv !== actv)
        begin
            $display("%0t: %s expected %0h got %0h", $time, name, expv, actv);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        wav_result_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result word with none expected, status %0d", $time, status);
                fail_count++;
            end
            else
            begin
                e = pending_results.pop_front();
                check_field("payload_valid", {31'd0, e.pv}, {31'd0, payload_valid});
                check_field("payload_byte", {24'd0, e.pb}, {24'd0, payload_byte});
                check_field("payload_last", {31'd0, e.pl}, {31'd0, payload_last});
                check_field("audio_format", {16'd0, e.fmt}, {16'd0, audio_format});
                check_field("num_channels", {16'd0, e.chans}, {16'd0, num_channels});
                check_field("sample_freq", e.rate, sample_freq);
                check_field("bits_per_sample", {16'd0, e.bits}, {16'd0, bits_per_sample});
                check_field("payload_size", e.psize, payload_size);
                check_field("status", {29'd0, e.status}, {29'd0, status});
            end
        end
    end

    // output side: random stalls, plus a long hold-off when asked
    initial
    begin : result_sink
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left == 0)
            begin
                if (hold_ask)
                begin
                    stall_left = 250;
                    hold_ask = 1'b0;
                end
                else if (!quiet && $urandom_range(0, 4) == 0)
                begin
                    stall_left = pick_gap_len();
                end
            end
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    initial
    begin : watchdog
        #10_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin : stimulus
        int          file_idx;
        int          sent_count;
        int          phase_files;
        int          target;
        file_kind_t  kind;
        logic [31:0] rnd;
        logic [3:0]  lim;
        rst_n = 1'b0;
        in_valid = 1'b0;
        byte_value = '0;
        end_of_file = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        out_stall = 1'b0;
        quiet = 1'b0;
        hold_ask = 1'b0;
        fail_count = 0;
        limit_reg = ChunkLimitReset;
        rearm_parser();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (DIRECTED_ROWS[i])
            send_byte(DIRECTED_ROWS[i].data, DIRECTED_ROWS[i].eof, DIRECTED_ROWS[i].pinned,
                      DIRECTED_ROWS[i].status);

        file_idx = 0;
        sent_count = 0;
        for (int p = 0; p < 7; p++)
        begin
            if (p != 0)
            begin
                rnd = $urandom_range(1, 15);
                lim = (p == 5) ? rnd[3:0] : LIMIT_PLAN[p];
                write_limit(lim);
            end
            // byte budget is spread evenly over the limit settings
            target = (p + 1) * ItemQuota / 7;
            phase_files = 0;
            while (phase_files == 0 || sent_count < target)
            begin
                // early files take the kinds in order, later ones are drawn at random
                kind = (file_idx < KindCount) ? file_kind_t'(file_idx) : pick_kind();
                quiet = ($urandom_range(0, 3) == 0);
                if ((p == 2 && phase_files == 0) || $urandom_range(0, 49) == 0)
                    hold_ask = 1'b1;
                if ($urandom_range(0, 19) == 0)
                    wait_drained();
                build_file(kind);
                foreach (file_q[i])
                begin
                    send_byte(file_q[i], i == file_q.size() - 1, 1'b0, StHeader);
                    sent_count++;
                end
                file_idx++;
                phase_files++;
            end
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
